// ===== hw/rtl/fspm_pkg.sv =====
// Shared types and constants for the frame slot pool manager.
// No dependencies; every other file in hw/rtl refers to this package.
`timescale 1ns / 1ps

package fspm_pkg;

    localparam int STAMP_W = 32;
    localparam int DIM_W   = 16;
    localparam int TIME_W  = 64;
    localparam int SLOT_W  = 5;

    localparam logic [1:0] OP_ACQUIRE = 2'd0;
    localparam logic [1:0] OP_COMMIT  = 2'd1;
    localparam logic [1:0] OP_NEXT    = 2'd2;

    // Input transaction payload.
    typedef struct packed {
        logic        [1:0]        opcode;
        logic        [DIM_W-1:0]  frame_width;
        logic        [DIM_W-1:0]  frame_height;
        logic signed [TIME_W-1:0] timestamp;
    } t_cmd;

    // Result transaction payload.
    typedef struct packed {
        logic                     found;
        logic        [SLOT_W-1:0] slot;
        logic        [STAMP_W-1:0] sequence_res;
        logic        [DIM_W-1:0]  out_width;
        logic        [DIM_W-1:0]  out_height;
        logic signed [TIME_W-1:0] out_timestamp;
    } t_res;

    // One entry of the per-slot metadata memory.
    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
    } t_meta;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;    // latch transaction, start scan, release consumer slot
        logic claim;   // take the scan winner, fetch its timestamp
        logic commit;  // write producer slot
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic scan_done;
    } t_dp_stat;

endpackage

// ===== hw/rtl/fspm_ctrl.sv =====
// Sequencing state machine for the frame slot pool manager.
// Depends on fspm_pkg for opcodes and the command/status structs.
`timescale 1ns / 1ps

module fspm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [1:0]         i_opcode,
    input  fspm_pkg::t_dp_stat i_dp_stat,
    output logic               o_busy,
    output logic               o_valid,
    output fspm_pkg::t_dp_cmd  o_dp_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_CLAIM  = 5'b00100,
        ST_COMMIT = 5'b01000,
        ST_DONE   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_dp_cmd = '0;
        o_busy   = 1'b1;
        o_valid  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_dp_cmd.load = 1'b1;
                    unique case (i_opcode)
                        fspm_pkg::OP_ACQUIRE: n_state = ST_SCAN;
                        fspm_pkg::OP_NEXT:    n_state = ST_SCAN;
                        fspm_pkg::OP_COMMIT:  n_state = ST_COMMIT;
                        default:              n_state = ST_DONE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (i_dp_stat.scan_done) begin
                    n_state = ST_CLAIM;
                end
            end
            ST_CLAIM: begin
                o_dp_cmd.claim = 1'b1;
                n_state        = ST_DONE;
            end
            ST_COMMIT: begin
                o_dp_cmd.commit = 1'b1;
                n_state         = ST_DONE;
            end
            ST_DONE: begin
                o_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted transaction did not raise busy");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_dp_cmd.load, o_dp_cmd.claim, o_dp_cmd.commit}))
        else $error("overlapping datapath commands");

    a_scan_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_stat.scan_done |-> (r_state == ST_SCAN))
        else $error("scan finished outside scan state");
`endif

endmodule

// ===== hw/rtl/fspm_datapath.sv =====
// Slot storage, sequential oldest-slot scan and result formation.
// Depends on fspm_pkg; driven by fspm_ctrl through t_dp_cmd.
`timescale 1ns / 1ps

module fspm_datapath #(
    parameter int SLOT_COUNT = 32,
    localparam int SW = $clog2(SLOT_COUNT)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fspm_pkg::t_cmd     i_cmd,
    input  fspm_pkg::t_dp_cmd  i_dp_cmd,
    output fspm_pkg::t_dp_stat o_dp_stat,
    output fspm_pkg::t_res     o_res
);

    localparam logic [SW-1:0] LAST = SW'(SLOT_COUNT - 1);

    // slot flags and metadata valid bits
    logic [SLOT_COUNT-1:0] r_in_use;
    logic [SLOT_COUNT-1:0] r_ready;
    logic [SLOT_COUNT-1:0] r_mvld;

    fspm_pkg::t_meta                    r_meta_mem [SLOT_COUNT];
    logic [fspm_pkg::TIME_W-1:0]        r_time_mem [SLOT_COUNT];

    fspm_pkg::t_cmd                     r_cmd;
    logic [fspm_pkg::STAMP_W-1:0]       r_counter;
    logic [SW-1:0]                      r_prod;
    logic [SW-1:0]                      r_cons;
    logic                               r_cons_held;

    // scan pipeline: issue stage then compare stage
    logic [SW-1:0]                      r_scan_addr;
    logic                               r_issue;
    logic                               r_rd_vld;
    logic [SW-1:0]                      r_rd_idx;
    logic                               r_rd_q;
    logic                               r_rd_mvld;
    fspm_pkg::t_meta                    r_rd_meta;

    logic                               r_best_found;
    logic [SW-1:0]                      r_best_idx;
    fspm_pkg::t_meta                    r_best_meta;
    logic [fspm_pkg::TIME_W-1:0]        r_time_rd;

    fspm_pkg::t_meta                    rd_meta;
    logic                               take;

    assign rd_meta = r_rd_mvld ? r_rd_meta : '0;
    assign take    = r_rd_vld && r_rd_q &&
                     (!r_best_found || (rd_meta.stamp < r_best_meta.stamp));

    assign o_dp_stat.scan_done = r_rd_vld && (r_rd_idx == LAST);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use     <= '0;
            r_ready      <= '0;
            r_mvld       <= '0;
            r_counter    <= '0;
            r_prod       <= '0;
            r_cons       <= '0;
            r_cons_held  <= 1'b0;
            r_scan_addr  <= '0;
            r_issue      <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_best_found <= 1'b0;
        end else begin
            r_rd_vld <= r_issue;
            if (i_dp_cmd.load) begin
                r_scan_addr  <= '0;
                r_issue      <= (i_cmd.opcode == fspm_pkg::OP_ACQUIRE) ||
                                (i_cmd.opcode == fspm_pkg::OP_NEXT);
                r_best_found <= 1'b0;
                if ((i_cmd.opcode == fspm_pkg::OP_NEXT) && r_cons_held) begin
                    r_in_use[r_cons] <= 1'b0;
                    r_ready[r_cons]  <= 1'b0;
                    r_cons_held      <= 1'b0;
                end
            end
            if (r_issue) begin
                r_scan_addr <= r_scan_addr + 1'b1;
                if (r_scan_addr == LAST) begin
                    r_issue <= 1'b0;
                end
            end
            if (take) begin
                r_best_found <= 1'b1;
            end
            if (i_dp_cmd.claim && r_best_found) begin
                r_in_use[r_best_idx] <= 1'b1;
                if (r_cmd.opcode == fspm_pkg::OP_ACQUIRE) begin
                    r_prod <= r_best_idx;
                end else begin
                    r_cons_held <= 1'b1;
                    r_cons      <= r_best_idx;
                end
            end
            if (i_dp_cmd.commit) begin
                r_counter        <= r_counter + 1'b1;
                r_ready[r_prod]  <= 1'b1;
                r_in_use[r_prod] <= 1'b0;
                r_mvld[r_prod]   <= 1'b1;
            end
        end
    end

    // payload and memories
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_cmd <= i_cmd;
        end
        if (r_issue) begin
            r_rd_meta <= r_meta_mem[r_scan_addr];
            r_rd_idx  <= r_scan_addr;
            r_rd_mvld <= r_mvld[r_scan_addr];
            r_rd_q    <= !r_in_use[r_scan_addr] &&
                         ((r_cmd.opcode != fspm_pkg::OP_NEXT) || r_ready[r_scan_addr]);
        end
        if (take) begin
            r_best_idx  <= r_rd_idx;
            r_best_meta <= rd_meta;
        end
        if (i_dp_cmd.claim) begin
            r_time_rd <= r_time_mem[r_best_idx];
        end
        if (i_dp_cmd.commit) begin
            r_meta_mem[r_prod] <= '{stamp:  r_counter + 1'b1,
                                    width:  r_cmd.frame_width,
                                    height: r_cmd.frame_height};
            r_time_mem[r_prod] <= r_cmd.timestamp;
        end
    end

    // result, stable while the controller strobes it
    always_comb begin
        o_res = '0;
        unique case (r_cmd.opcode)
            fspm_pkg::OP_ACQUIRE, fspm_pkg::OP_NEXT: begin
                if (r_best_found) begin
                    o_res.found        = 1'b1;
                    o_res.slot         = fspm_pkg::SLOT_W'(r_best_idx);
                    o_res.sequence_res = r_best_meta.stamp;
                    o_res.out_width    = r_best_meta.width;
                    o_res.out_height   = r_best_meta.height;
                    if (r_cmd.opcode == fspm_pkg::OP_NEXT) begin
                        o_res.out_timestamp = r_time_rd;
                    end
                end
            end
            fspm_pkg::OP_COMMIT: begin
                o_res.found         = 1'b1;
                o_res.slot          = fspm_pkg::SLOT_W'(r_prod);
                o_res.sequence_res  = r_counter;
                o_res.out_width     = r_cmd.frame_width;
                o_res.out_height    = r_cmd.frame_height;
                o_res.out_timestamp = r_cmd.timestamp;
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/frame_slot_pool_manager.sv =====
// Top level of the frame slot pool manager.
// Depends on fspm_pkg, fspm_ctrl and fspm_datapath.
`timescale 1ns / 1ps

// Frame slot pool manager: bookkeeping for SLOT_COUNT frame buffers shared by
// one producer and one consumer.
//
// Input channel: a transaction (opcode plus frame metadata in i_cmd) is taken
// at a clock edge with start high and busy low. busy stays high until the
// result has been shown, so one transaction is in flight at a time.
// Result channel: o_result is valid for exactly one cycle while o_valid is
// high; the receiver cannot stall and must take it in that cycle.
//
// Sequence from the accepting edge to the strobe cycle:
//   acquire / consumer next : a scan of one slot per cycle through the
//                             metadata memory read port, then a claim
//                             state that also reads the timestamp.
//   commit / unused opcode  : a commit state / no intermediate state.
//
// Reset (synchronous, active low) clears all in-use, ready and metadata
// valid bits, the stamp counter, the producer slot and the consumer hold.
// Metadata of never-written slots reads as zero; no clearing pass is needed.

module frame_slot_pool_manager #(
    parameter int SLOT_COUNT = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  fspm_pkg::t_cmd i_cmd,
    output logic           o_valid,
    output fspm_pkg::t_res o_result
);

    fspm_pkg::t_dp_cmd  dp_cmd;
    fspm_pkg::t_dp_stat dp_stat;

    // controller: sequences load, scan, claim/commit and the result strobe
    fspm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_opcode  (i_cmd.opcode),
        .i_dp_stat (dp_stat),
        .o_busy    (busy),
        .o_valid   (o_valid),
        .o_dp_cmd  (dp_cmd)
    );

    // datapath: slot flags, metadata memories, scan compare, result mux
    fspm_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .i_dp_cmd  (dp_cmd),
        .o_dp_stat (dp_stat),
        .o_res     (o_result)
    );

endmodule

// ===== dv/tb_frame_slot_pool_manager.sv =====
// Self-checking testbench for frame_slot_pool_manager: directed table, then random traffic.
// Depends on fspm_pkg and the RTL top level. Results are checked against a predictor.
`timescale 1ns / 1ps

module tb_frame_slot_pool_manager;

    localparam int SLOTS        = 32;
    localparam int DRAIN_CYCLES = SLOTS + 8;      // longest latency plus margin
    localparam int CYCLE_LIMIT  = 400000;         // several times the slowest clean run

    // Opcode 3 is not defined by the block; it must return an all-zero result.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [63:0] TS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] TS_MIN = 64'h8000_0000_0000_0000;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    fspm_pkg::t_cmd cmd;
    logic           o_valid;
    fspm_pkg::t_res o_result;

    frame_slot_pool_manager #(
        .SLOT_COUNT(SLOTS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (cmd),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Pool model. 2-state types so everything starts at zero, which is the
    // reset state of the block. Timestamps of unwritten slots are never read:
    // only ready slots report a time and only a commit sets ready.
    // ------------------------------------------------------------------
    bit          in_use     [SLOTS];
    bit          ready_mark [SLOTS];
    bit [31:0]   stamp      [SLOTS];
    bit [15:0]   wid        [SLOTS];
    bit [15:0]   hgt        [SLOTS];
    bit [63:0]   ts         [SLOTS];
    bit [31:0]   seq_ctr;
    int          prod_idx;
    bit          cons_held;
    int          cons_idx;

    fspm_pkg::t_res pending_results [$];  // expected results, oldest first
    int          mismatches;
    int          cycles;

    // Hand-typed expectation for the transaction now being offered (directed rows).
    bit             hand_expect_on;
    fspm_pkg::t_res hand_expect;

    bit          quiet;                   // no sender idling while set
    int          n_items;                 // defined-opcode transactions sent

    typedef struct {
        fspm_pkg::t_cmd cmd;
        bit             has_exp;
        fspm_pkg::t_res exp;
    } t_dir_row;

    t_dir_row dir_rows [$];

    function automatic void queue_expected(fspm_pkg::t_res r);
        pending_results = {pending_results, r};
    endfunction

    function automatic void add_row(fspm_pkg::t_cmd c, bit has_exp, fspm_pkg::t_res exp);
        t_dir_row row;
        row.cmd     = c;
        row.has_exp = has_exp;
        row.exp     = exp;
        dir_rows    = {dir_rows, row};
    endfunction

    function automatic fspm_pkg::t_cmd mk_cmd(logic [1:0] op, logic [15:0] w,
                                              logic [15:0] h, logic [63:0] t);
        fspm_pkg::t_cmd c;
        c.opcode       = op;
        c.frame_width  = w;
        c.frame_height = h;
        c.timestamp    = t;
        return c;
    endfunction

    function automatic fspm_pkg::t_res mk_res(bit f, logic [4:0] s, logic [31:0] q,
                                              logic [15:0] w, logic [15:0] h,
                                              logic [63:0] t);
        fspm_pkg::t_res r;
        r.found         = f;
        r.slot          = s;
        r.sequence_res  = q;
        r.out_width     = w;
        r.out_height    = h;
        r.out_timestamp = t;
        return r;
    endfunction

    // Dimensions and times lean toward the extremes now and then.
    function automatic logic [15:0] rand_dim();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic fspm_pkg::t_cmd rand_cmd(logic [1:0] op);
        logic [63:0] t;
        case ($urandom_range(0, 9))
            0:       t = TS_MIN;
            1:       t = TS_MAX;
            2:       t = '0;
            3:       t = '1;
            default: t = {$urandom, $urandom};
        endcase
        return mk_cmd(op, rand_dim(), rand_dim(), t);
    endfunction

    // Lowest stamp among slots not in use (and ready, if asked); lowest index on a tie.
    function automatic int oldest_free(bit need_ready);
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (!in_use[i] && (!need_ready || ready_mark[i]) &&
                (best < 0 || stamp[i] < stamp[best]))
                best = i;
        end
        return best;
    endfunction

    // Applies one transaction to the pool model and returns the result it must produce.
    function automatic fspm_pkg::t_res pool_step(fspm_pkg::t_cmd c);
        fspm_pkg::t_res r;
        int   idx;
        int   p;
        r = '0;
        case (c.opcode)
            fspm_pkg::OP_ACQUIRE: begin
                idx = oldest_free(1'b0);
                if (idx >= 0) begin
                    in_use[idx] = 1'b1;
                    prod_idx    = idx;
                    // acquire never reports a time
                    r = mk_res(1'b1, idx[4:0], stamp[idx], wid[idx], hgt[idx], '0);
                end
            end
            fspm_pkg::OP_COMMIT: begin
                // acts on the producer slot as it stands, acquired or not
                p             = prod_idx;
                seq_ctr       = seq_ctr + 1;
                stamp[p]      = seq_ctr;
                wid[p]        = c.frame_width;
                hgt[p]        = c.frame_height;
                ts[p]         = c.timestamp;
                ready_mark[p] = 1'b1;
                in_use[p]     = 1'b0;
                r = mk_res(1'b1, p[4:0], stamp[p], wid[p], hgt[p], ts[p]);
            end
            fspm_pkg::OP_NEXT: begin
                // release first, even when no new frame turns out to be ready
                if (cons_held) begin
                    in_use[cons_idx]     = 1'b0;
                    ready_mark[cons_idx] = 1'b0;
                    cons_held            = 1'b0;
                end
                idx = oldest_free(1'b1);
                if (idx >= 0) begin
                    in_use[idx] = 1'b1;
                    cons_held   = 1'b1;
                    cons_idx    = idx;
                    r = mk_res(1'b1, idx[4:0], stamp[idx], wid[idx], hgt[idx], ts[idx]);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic check_result(fspm_pkg::t_res want, fspm_pkg::t_res got);
        if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            mismatches++;
        end
        if (got.slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, got.slot);
            mismatches++;
        end
        if (got.sequence_res !== want.sequence_res) begin
            $error("sequence_res: expected %0d, got %0d", want.sequence_res, got.sequence_res);
            mismatches++;
        end
        if (got.out_width !== want.out_width) begin
            $error("out_width: expected %0d, got %0d", want.out_width, got.out_width);
            mismatches++;
        end
        if (got.out_height !== want.out_height) begin
            $error("out_height: expected %0d, got %0d", want.out_height, got.out_height);
            mismatches++;
        end
        if (got.out_timestamp !== want.out_timestamp) begin
            $error("out_timestamp: expected %0d, got %0d",
                   want.out_timestamp, got.out_timestamp);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge. A result strobe is
    // checked before a new transaction is predicted; busy stays high while the
    // result is shown, so no command is taken on the edge a result leaves.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        fspm_pkg::t_res want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (pending_results.size() == 0) begin
                    $error("result for slot %0d with no transaction pending", o_result.slot);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    check_result(want, o_result);
                end
            end
            if (start && !busy) begin
                // model always advances; directed rows may override the value checked
                want = pool_step(cmd);
                queue_expected(hand_expect_on ? hand_expect : want);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender. Inputs move on the falling edge. busy only changes on the
    // rising edge, so busy seen at a falling edge tells whether the command
    // goes in at the next rising edge. start is left high after a transaction
    // and only lowered for an idle gap, so it never drops and rises in one step.
    // ------------------------------------------------------------------
    task automatic issue(input fspm_pkg::t_cmd c, input bit has_exp = 1'b0,
                         input fspm_pkg::t_res exp = '0);
        if (!quiet && $urandom_range(0, 99) < 30) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 40)) @(negedge i_clk);
        end
        start          <= 1'b1;
        cmd            <= c;
        hand_expect_on  = has_exp;
        hand_expect     = exp;
        while (busy) @(negedge i_clk);
        @(negedge i_clk);               // taken at the edge just passed
        hand_expect_on  = 1'b0;
        if (c.opcode != OP_UNUSED)
            n_items++;
    endtask

    // Holds off until every outstanding result has been seen.
    task automatic drain_pool_results();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int  pick;
        bit  paused;
        start          = 1'b0;
        cmd            = '0;
        i_rst_n        = 1'b0;
        hand_expect_on = 1'b0;
        hand_expect    = '0;
        quiet          = 1'b0;
        paused         = 1'b0;
        n_items        = 0;
        mismatches     = 0;

        // Directed table. Rows with a typed result follow at a glance from the
        // reset state; the rest lean on the predictor.
        // unused opcode with every field bit set: nothing changes, all-zero result
        add_row(mk_cmd(OP_UNUSED, '1, '1, '1), 1'b1, '0);
        // consumer asks with nothing ready
        add_row(mk_cmd(fspm_pkg::OP_NEXT, '1, '1, '1), 1'b1, '0);
        // commit without acquire lands on slot 0, full-scale metadata
        add_row(mk_cmd(fspm_pkg::OP_COMMIT, '1, '1, TS_MAX), 1'b1,
                mk_res(1'b1, 5'd0, 32'd1, '1, '1, TS_MAX));
        // slot 0 now has stamp 1, so acquire picks slot 1 (stamp 0)
        add_row(mk_cmd(fspm_pkg::OP_ACQUIRE, '1, '1, TS_MIN), 1'b1,
                mk_res(1'b1, 5'd1, 32'd0, '0, '0, '0));
        add_row(mk_cmd(fspm_pkg::OP_COMMIT, '0, '0, TS_MIN), 1'b1,
                mk_res(1'b1, 5'd1, 32'd2, '0, '0, TS_MIN));
        // consumer gets oldest first
        add_row(mk_cmd(fspm_pkg::OP_NEXT, '0, '0, '0), 1'b1,
                mk_res(1'b1, 5'd0, 32'd1, '1, '1, TS_MAX));
        add_row(mk_cmd(fspm_pkg::OP_NEXT, '0, '0, '0), 1'b1,
                mk_res(1'b1, 5'd1, 32'd2, '0, '0, TS_MIN));
        // releases slot 1 and finds nothing
        add_row(mk_cmd(fspm_pkg::OP_NEXT, '0, '0, '0), 1'b1, '0);
        // producer slot still 1: commit again without acquire
        add_row(rand_cmd(fspm_pkg::OP_COMMIT), 1'b0, '0);
        add_row(rand_cmd(fspm_pkg::OP_ACQUIRE), 1'b0, '0);
        add_row(rand_cmd(fspm_pkg::OP_NEXT), 1'b0, '0);
        add_row(mk_cmd(fspm_pkg::OP_COMMIT, 16'd1, 16'd1, '0), 1'b0, '0);
        // second commit overwrites a ready frame that nobody consumed
        add_row(rand_cmd(fspm_pkg::OP_COMMIT), 1'b0, '0);
        // consumer takes the producer's slot, then the producer commits on it
        add_row(rand_cmd(fspm_pkg::OP_NEXT), 1'b0, '0);
        add_row(rand_cmd(fspm_pkg::OP_COMMIT), 1'b0, '0);
        // release wipes that frame's ready mark: nothing left to hand out
        add_row(rand_cmd(fspm_pkg::OP_NEXT), 1'b0, '0);
        add_row(rand_cmd(OP_UNUSED), 1'b0, '0);
        add_row(rand_cmd(fspm_pkg::OP_ACQUIRE), 1'b0, '0);
        add_row(rand_cmd(fspm_pkg::OP_COMMIT), 1'b0, '0);
        add_row(rand_cmd(fspm_pkg::OP_NEXT), 1'b0, '0);

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i])
            issue(dir_rows[i].cmd, dir_rows[i].has_exp, dir_rows[i].exp);

        // Random traffic, mostly well-formed producer/consumer sequences.
        // Acquires without a commit leak slots for good, so they wait for the end.
        while (n_items < 900) begin
            quiet = (n_items >= 300 && n_items < 450);
            if (!paused && n_items >= 200) begin
                drain_pool_results();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                // produce a frame, sometimes with the consumer working meanwhile
                issue(rand_cmd(fspm_pkg::OP_ACQUIRE));
                if ($urandom_range(0, 99) < 30)
                    repeat ($urandom_range(1, 3)) issue(rand_cmd(fspm_pkg::OP_NEXT));
                issue(rand_cmd(fspm_pkg::OP_COMMIT));
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 3)) issue(rand_cmd(fspm_pkg::OP_NEXT));
            end else if (pick < 88) begin
                issue(rand_cmd(fspm_pkg::OP_COMMIT));       // commit with no acquire
            end else if (pick < 93) begin
                issue(rand_cmd(OP_UNUSED));
            end else begin
                issue(rand_cmd(fspm_pkg::OP_ACQUIRE));
                issue(rand_cmd(fspm_pkg::OP_COMMIT));
                issue(rand_cmd(fspm_pkg::OP_COMMIT));       // repeat commit on same slot
            end
        end

        // Exhaust the pool: more acquires than slots, then recover a little.
        quiet = 1'b0;
        drain_pool_results();
        repeat (SLOTS + 2) issue(rand_cmd(fspm_pkg::OP_ACQUIRE));
        issue(rand_cmd(fspm_pkg::OP_COMMIT));
        issue(rand_cmd(fspm_pkg::OP_NEXT));
        issue(rand_cmd(fspm_pkg::OP_NEXT));
        issue(rand_cmd(fspm_pkg::OP_ACQUIRE));
        issue(rand_cmd(fspm_pkg::OP_ACQUIRE));
        issue(rand_cmd(fspm_pkg::OP_COMMIT));

        start <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
